FILE: rtl/core/dvsp_pkg.sv
// Shared types, character codes and helpers for the version string parser.
`default_nettype none

package dvsp_pkg;

    // Slots in the packed 64-bit result
    localparam int SLOT_FIELDS = 4;
    localparam int FIELD_BITS  = 16;
    localparam int VER_W       = SLOT_FIELDS * FIELD_BITS;

    // At most four digits per field: 9999 fits in 14 bits
    localparam int MAG_W = 14;

    // Register map
    localparam int   APB_AW           = 3;
    localparam int   REG_IDX_W        = APB_AW - 2;
    localparam logic [REG_IDX_W-1:0] REG_VERSION_MODE = 1'b0;

    // version_mode codes
    localparam logic MODE_OPENGL = 1'b0;
    localparam logic MODE_VULKAN = 1'b1;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Per-field scan phase of the atoi-style conversion
    typedef enum logic [1:0] {
        PH_BLANK,
        PH_DIGIT,
        PH_DONE
    } t_scan_phase;

    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/driver_version_string_parser.sv
// Top level of the dotted driver version string parser.
//
// Usage:
//  - Input channel (i_valid / o_ready): one beat per string character on
//    i_character, then one beat with i_end_of_string high that closes the
//    string. Characters of a string may arrive in consecutive cycles.
//  - Output channel (o_valid / i_ready): exactly one beat per end marker,
//    o_version packs four 16-bit fields (first field in bits 63..48) and
//    o_valid_res flags a well-formed string; o_version is zero when not.
//  - APB port: register 0 (byte address 0) is version_mode, bit 0:
//    0 OpenGL (later fields right-padded with '0'), 1 Vulkan (short form ok).
//    Write it only while the parser is idle.
//  - Throughput: one beat per cycle, except while an end marker waits for
//    room in the result register. The end-marker beat passes the input
//    register, then the result register, before o_valid rises.
//  - The result register decouples the sides: while a result waits, character
//    beats keep flowing; only a second end marker stalls in the input register.
//  - Reset (i_rst_n low, synchronous) empties both registers, clears the
//    field splitter and sets version_mode to OpenGL.
`default_nettype none

module driver_version_string_parser #(
    parameter int FIELD_COUNT     = 4,
    parameter int CHARS_PER_FIELD = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Character stream
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [7:0]                   i_character,
    input  wire logic                         i_end_of_string,
    // Result stream
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [dvsp_pkg::VER_W-1:0]        o_version,
    output logic                              o_valid_res,
    // Configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dvsp_pkg::APB_AW-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import dvsp_pkg::*;

    localparam int LW = $clog2(CHARS_PER_FIELD + 1);

    // Configuration register
    logic r_mode;
    logic cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[APB_AW-1:2] == REG_VERSION_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OPENGL;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_mode <= pwdata[0];
        end
    end

    assign prdata = cfg_sel ? {31'b0, r_mode} : '0;

    // Input register
    logic       r_s1_vld;
    logic [7:0] r_s1_char;
    logic       r_s1_eos;
    logic       out_free;
    logic       s1_go;
    logic       out_load;

    assign out_free = !o_valid || i_ready;
    // Characters always drain; an end marker needs room in the result reg
    assign s1_go    = r_s1_vld && (!r_s1_eos || out_free);
    assign o_ready  = !r_s1_vld || s1_go;
    assign out_load = s1_go && r_s1_eos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_ready) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_char <= i_character;
            r_s1_eos  <= i_end_of_string;
        end
    end

    // Field splitter
    logic [7:0]    w_chars [FIELD_COUNT][CHARS_PER_FIELD];
    logic [LW-1:0] w_lens  [FIELD_COUNT];
    logic          w_count_ok;

    dvsp_collect #(
        .FIELD_COUNT     (FIELD_COUNT),
        .CHARS_PER_FIELD (CHARS_PER_FIELD)
    ) u_collect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_beat_vld (s1_go),
        .i_char     (r_s1_char),
        .i_eos      (r_s1_eos),
        .i_mode     (r_mode),
        .o_chars    (w_chars),
        .o_lens     (w_lens),
        .o_count_ok (w_count_ok)
    );

    // One converter per field, all working in parallel
    logic [FIELD_BITS-1:0] w_val [FIELD_COUNT];
    logic [FIELD_COUNT-1:0] w_neg;

    for (genvar f = 0; f < FIELD_COUNT; f++) begin : g_conv
        dvsp_field_conv #(
            .CHARS_PER_FIELD (CHARS_PER_FIELD)
        ) u_conv (
            .i_chars   (w_chars[f]),
            .i_len     (w_lens[f]),
            .i_pad     ((r_mode == MODE_OPENGL) && (f > 0)),
            .o_value   (w_val[f]),
            .o_neg_bad (w_neg[f])
        );
    end

    // Pack fields high to low; unused low slots stay zero
    logic [VER_W-1:0] ver_pack;
    logic             res_ok;

    always_comb begin
        ver_pack = '0;
        for (int f = 0; f < FIELD_COUNT; f++) begin
            ver_pack[VER_W-1-FIELD_BITS*f -: FIELD_BITS] = w_val[f];
        end
    end

    assign res_ok = w_count_ok && (w_neg == '0);

    // Result register
    logic             r_out_vld;
    logic [VER_W-1:0] r_version;
    logic             r_valid_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_version   <= res_ok ? ver_pack : '0;
            r_valid_res <= res_ok;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_version   = r_version;
    assign o_valid_res = r_valid_res;

`ifndef SYNTHESIS
    // A rejected string never leaks field data
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> o_version == '0)
        else $error("invalid result with nonzero version");

    // Three-field builds leave the lowest slot empty
    a_low_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FIELD_COUNT < SLOT_FIELDS) && o_valid |-> o_version[FIELD_BITS-1:0] == '0)
        else $error("unused low field slot is nonzero");

    // A result only appears after an end-marker beat left the input register
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_s1_vld && r_s1_eos))
        else $error("result without end marker");

    // A held end marker keeps its beat until the result register frees up
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_go |=> r_s1_vld && r_s1_eos && $stable(r_s1_char))
        else $error("stalled input beat lost");

    // The first field holds at most four digits
    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res |-> o_version[VER_W-1 -: FIELD_BITS] <= 16'd9999)
        else $error("field value out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/dvsp_field_conv.sv
// Combinational atoi-style conversion of one stored version field.
`default_nettype none

module dvsp_field_conv #(
    parameter int CHARS_PER_FIELD = 4
) (
    input  wire logic [7:0]                           i_chars [CHARS_PER_FIELD],
    input  wire logic [$clog2(CHARS_PER_FIELD+1)-1:0] i_len,
    input  wire logic                                 i_pad,
    output logic [dvsp_pkg::FIELD_BITS-1:0]           o_value,
    output logic                                      o_neg_bad
);
    import dvsp_pkg::*;

    localparam int LW = $clog2(CHARS_PER_FIELD + 1);

    logic [LW-1:0]    elen;
    logic [7:0]       ch;
    logic [MAG_W-1:0] mag;
    logic             neg;
    t_scan_phase      phase;

    // Padding fills the field with '0' up to its full width
    assign elen = i_pad ? LW'(CHARS_PER_FIELD) : i_len;

    always_comb begin
        mag   = '0;
        neg   = 1'b0;
        phase = PH_BLANK;
        ch    = CH_ZERO;
        for (int i = 0; i < CHARS_PER_FIELD; i++) begin
            ch = (LW'(i) < i_len) ? i_chars[i] : CH_ZERO;
            if (LW'(i) < elen) begin
                case (phase)
                    PH_BLANK: begin
                        if (is_blank(ch)) begin
                            phase = PH_BLANK;
                        end else if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
                            neg   = (ch == CH_MINUS);
                            phase = PH_DIGIT;
                        end else if (is_digit(ch)) begin
                            mag   = MAG_W'(ch - CH_ZERO);
                            phase = PH_DIGIT;
                        end else begin
                            phase = PH_DONE;
                        end
                    end
                    PH_DIGIT: begin
                        if (is_digit(ch)) begin
                            mag = (mag << 3) + (mag << 1) + MAG_W'(ch - CH_ZERO);
                        end else begin
                            phase = PH_DONE;
                        end
                    end
                    default: begin
                        phase = PH_DONE;
                    end
                endcase
            end
        end
    end

    assign o_value   = FIELD_BITS'(mag);
    assign o_neg_bad = neg && (mag != '0);

endmodule

`default_nettype wire

FILE: rtl/core/dvsp_collect.sv
// Splits the character stream into fields and holds the kept characters.
`default_nettype none

module dvsp_collect #(
    parameter int FIELD_COUNT     = 4,
    parameter int CHARS_PER_FIELD = 4
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_beat_vld,
    input  wire logic [7:0]                           i_char,
    input  wire logic                                 i_eos,
    input  wire logic                                 i_mode,
    output logic [7:0]                                o_chars [FIELD_COUNT][CHARS_PER_FIELD],
    output logic [$clog2(CHARS_PER_FIELD+1)-1:0]      o_lens  [FIELD_COUNT],
    output logic                                      o_count_ok
);
    import dvsp_pkg::*;

    localparam int LW  = $clog2(CHARS_PER_FIELD + 1);
    localparam int FIW = $clog2(FIELD_COUNT + 1);
    localparam int FXW = $clog2(FIELD_COUNT);
    localparam int CXW = (CHARS_PER_FIELD > 1) ? $clog2(CHARS_PER_FIELD) : 1;

    logic [FIW-1:0] r_fi, n_fi;
    logic [LW-1:0]  r_cp, n_cp;
    logic [LW-1:0]  r_lens [FIELD_COUNT];
    logic [LW-1:0]  n_lens [FIELD_COUNT];
    logic           r_bad, n_bad;
    logic           r_nul, n_nul;
    logic [7:0]     r_chars [FIELD_COUNT][CHARS_PER_FIELD];
    logic           chr_we;
    logic [FIW-1:0] fi_eff;

    // Next-state of the splitter
    always_comb begin
        n_fi   = r_fi;
        n_cp   = r_cp;
        n_lens = r_lens;
        n_bad  = r_bad;
        n_nul  = r_nul;
        chr_we = 1'b0;
        if (i_beat_vld) begin
            if (i_eos) begin
                n_fi  = '0;
                n_cp  = '0;
                n_bad = 1'b0;
                n_nul = 1'b0;
                for (int f = 0; f < FIELD_COUNT; f++) begin
                    n_lens[f] = '0;
                end
            end else if (!r_bad && !r_nul) begin
                if (i_char == CH_NUL) begin
                    n_nul = 1'b1;
                end else if (r_fi == FIW'(FIELD_COUNT)) begin
                    n_bad = 1'b1;
                end else if (i_char == CH_DOT) begin
                    n_lens[r_fi[FXW-1:0]] = r_cp;
                    n_fi = r_fi + FIW'(1);
                    n_cp = '0;
                end else if (r_cp < LW'(CHARS_PER_FIELD)) begin
                    chr_we = 1'b1;
                    n_cp   = r_cp + LW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fi  <= '0;
            r_cp  <= '0;
            r_bad <= 1'b0;
            r_nul <= 1'b0;
            for (int f = 0; f < FIELD_COUNT; f++) begin
                r_lens[f] <= '0;
            end
        end else begin
            r_fi   <= n_fi;
            r_cp   <= n_cp;
            r_bad  <= n_bad;
            r_nul  <= n_nul;
            r_lens <= n_lens;
        end
    end

    // Character store: only entries written in the current string are read
    always_ff @(posedge i_clk) begin
        if (chr_we) begin
            r_chars[r_fi[FXW-1:0]][r_cp[CXW-1:0]] <= i_char;
        end
    end

    assign o_chars = r_chars;

    // View of the string as if it ended now: close the open field and
    // supply the short-form last field in Vulkan mode
    always_comb begin
        o_lens = r_lens;
        fi_eff = r_fi;
        if (!r_bad && (r_fi < FIW'(FIELD_COUNT))) begin
            o_lens[r_fi[FXW-1:0]] = r_cp;
        end
        if (!r_bad && (i_mode == MODE_VULKAN) && (r_fi == FIW'(FIELD_COUNT - 2))) begin
            fi_eff                 = FIW'(FIELD_COUNT - 1);
            o_lens[FIELD_COUNT-1]  = '0;
        end
        o_count_ok = !r_bad && (fi_eff == FIW'(FIELD_COUNT - 1));
    end

endmodule

`default_nettype wire

FILE: sim/driver_version_string_parser_tb.sv
// Self-checking testbench for the dotted driver version string parser.
`timescale 1ns / 1ps

module driver_version_string_parser_tb;
    import dvsp_pkg::*;

    localparam int NUM_FIELDS   = 4;
    localparam int FIELD_CHARS  = 4;
    localparam int HANG_LIMIT   = 5000;   // quiet cycles before we call it a hang
    localparam int SETTLE_LAT   = 4;      // settling wait after the last result
    localparam int HOLD_CYCLES  = 300;    // long receiver hold in the pressure test
    localparam logic [APB_AW-1:0] MODE_ADDR = {REG_VERSION_MODE, 2'b00};

    typedef struct packed {
        logic [VER_W-1:0] version;
        logic             valid_res;
    } t_version_result;

    // Clock, reset and DUT ports; every input starts at a known value
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [7:0]        i_character = 8'h00;
    logic              i_end_of_string = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [VER_W-1:0]  o_version;
    logic              o_valid_res;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Expected parser results, oldest first
    t_version_result expected_versions[$];

    // Parser shadow state, updated on every accepted beat
    logic       mdl_mode;
    int         mdl_dots;
    int         mdl_pos;
    logic [7:0] mdl_chars[NUM_FIELDS*FIELD_CHARS];
    int         mdl_len[NUM_FIELDS];
    bit         mdl_bad;
    bit         mdl_nul;

    // Traffic shaping knobs, set per test
    int max_gap   = 5;
    int max_stall = 5;
    int hold_req  = 0;

    // Bookkeeping
    int error_count   = 0;
    int beats_sent    = 0;
    int results_seen  = 0;
    int valid_results = 0;
    int quiet_cycles  = 0;

    logic [7:0] text[$];   // string under construction

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    driver_version_string_parser #(
        .FIELD_COUNT     (NUM_FIELDS),
        .CHARS_PER_FIELD (FIELD_CHARS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_character     (i_character),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_version       (o_version),
        .o_valid_res     (o_valid_res),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // Appends one byte to the string under construction
    function automatic void add_char(logic [7:0] c);
        text.insert(text.size(), c);
    endfunction

    // ---------------------------------------------------------------
    // Shadow parser
    // ---------------------------------------------------------------
    function automatic void clear_parse_state();
        mdl_dots = 0;
        mdl_pos  = 0;
        mdl_bad  = 1'b0;
        mdl_nul  = 1'b0;
        foreach (mdl_chars[k]) mdl_chars[k] = 8'h00;
        foreach (mdl_len[k]) mdl_len[k] = 0;
    endfunction

    // atoi on one stored field; returns 0 when it holds a negative nonzero value or exceeds 16 bits
    function automatic bit field_to_int(int f, bit pad, output logic [15:0] value);
        logic [7:0]  fbytes[FIELD_CHARS];
        int          len;
        int          i;
        int unsigned mag;
        bit          neg;
        len = (mdl_len[f] > FIELD_CHARS) ? FIELD_CHARS : mdl_len[f];
        for (i = 0; i < len; i++) fbytes[i] = mdl_chars[f*FIELD_CHARS + i];
        if (pad) begin
            for (; len < FIELD_CHARS; len++) fbytes[len] = CH_ZERO;
        end
        i   = 0;
        mag = 0;
        neg = 1'b0;
        // skip space and TAB..CR
        while (i < len && (fbytes[i] == CH_SPACE || (fbytes[i] >= CH_TAB && fbytes[i] <= CH_CR)))
            i++;
        if (i < len && (fbytes[i] == CH_PLUS || fbytes[i] == CH_MINUS)) begin
            neg = (fbytes[i] == CH_MINUS);
            i++;
        end
        while (i < len && fbytes[i] >= CH_ZERO && fbytes[i] <= CH_NINE) begin
            mag = mag * 10 + (fbytes[i] - CH_ZERO);
            i++;
        end
        value = mag[15:0];
        return !(neg && mag != 0) && mag <= 32'hffff;
    endfunction

    function automatic void predict_beat(logic [7:0] ch, logic eos);
        bit               ok;
        logic [VER_W-1:0] ver;
        logic [15:0]      v;
        t_version_result  res;
        if (!eos) begin
            if (mdl_bad || mdl_nul) return;
            if (ch == CH_NUL) begin
                mdl_nul = 1'b1;         // rest of the string is dead
                return;
            end
            if (mdl_dots >= NUM_FIELDS) begin
                mdl_bad = 1'b1;         // anything past the last field
                return;
            end
            if (ch == CH_DOT) begin
                mdl_len[mdl_dots] = mdl_pos;
                mdl_dots++;
                mdl_pos = 0;
                return;
            end
            if (mdl_pos >= FIELD_CHARS) return;   // long field, drop extras
            mdl_chars[mdl_dots*FIELD_CHARS + mdl_pos] = ch;
            mdl_pos++;
            return;
        end
        ok  = !mdl_bad;
        ver = '0;
        if (ok && mdl_dots < NUM_FIELDS) mdl_len[mdl_dots] = mdl_pos;
        // Vulkan short form: missing last field reads as zero
        if (ok && mdl_mode == MODE_VULKAN && mdl_dots == NUM_FIELDS - 2) begin
            mdl_dots++;
            mdl_len[mdl_dots] = 0;
        end
        if (mdl_dots != NUM_FIELDS - 1) ok = 1'b0;
        for (int f = 0; ok && f < NUM_FIELDS; f++) begin
            if (!field_to_int(f, mdl_mode == MODE_OPENGL && f > 0, v)) ok = 1'b0;
            ver |= {48'h0, v} << (48 - 16*f);
        end
        res.version   = ok ? ver : '0;
        res.valid_res = ok;
        expected_versions.insert(expected_versions.size(), res);
        clear_parse_state();
    endfunction

    // ---------------------------------------------------------------
    // Character stream driver
    // ---------------------------------------------------------------
    task automatic send_beat(logic [7:0] ch, logic eos);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_character     <= ch;
        i_end_of_string <= eos;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_beat(ch, eos);
        beats_sent++;
    endtask

    // Sends the queued text and closes it; the end-marker byte is junk on purpose
    task automatic send_text();
        foreach (text[k]) send_beat(text[k], 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic load_text(string s);
        text.delete();
        for (int k = 0; k < s.len(); k++) add_char(s[k]);
    endtask

    task automatic send_string(string s);
        load_text(s);
        send_text();
    endtask

    // Drop valid, let every pending result come back, then let the pipe settle
    task automatic wait_for_idle();
        i_valid <= 1'b0;
        while (expected_versions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_LAT) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // APB
    // ---------------------------------------------------------------
    task automatic apb_access(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MODE_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        if (wr) mdl_mode = wdata[0];    // register takes the value at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mode(logic m);
        logic [31:0] rd;
        apb_access(1'b1, {31'b0, m}, rd);
        apb_access(1'b0, '0, rd);
        if (rd[0] !== m)
            report_mismatch($sformatf("version_mode read back %0b, wrote %0b", rd[0], m));
    endtask

    // ---------------------------------------------------------------
    // Random string builder: mostly well-formed with random content,
    // some with damage spliced in, some pure noise
    // ---------------------------------------------------------------
    task automatic build_random_text();
        int kind;
        int nf;
        int nd;
        logic [7:0] junk;
        text.delete();
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            repeat ($urandom_range(0, 12)) begin
                junk = ($urandom_range(0, 3) == 0) ? CH_DOT : 8'($urandom_range(0, 255));
                add_char(junk);
            end
            return;
        end
        nf = ($urandom_range(0, 3) == 0) ? NUM_FIELDS - 1 : NUM_FIELDS;
        for (int f = 0; f < nf; f++) begin
            if (f != 0) add_char(CH_DOT);
            case ($urandom_range(0, 15))
                0: add_char(CH_SPACE);
                1: add_char(8'($urandom_range(CH_TAB, CH_CR)));
                2: add_char(CH_MINUS);
                3: add_char(CH_PLUS);
                default: ;
            endcase
            nd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 4);
            repeat (nd) add_char(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        if (kind >= 7) begin
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, 3))
                    0: junk = CH_DOT;
                    1: junk = CH_NUL;
                    default: junk = 8'($urandom_range(0, 255));
                endcase
                text.insert($urandom_range(0, text.size()), junk);
            end
        end
    endtask

    task automatic random_phase(int budget);
        int stop_at;
        stop_at = beats_sent + budget;
        while (beats_sent < stop_at) begin
            build_random_text();
            send_text();
        end
        wait_for_idle();
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_register_access();
        set_mode(MODE_VULKAN);
        set_mode(MODE_OPENGL);
    endtask

    // Padding, atoi corner cases, long fields, top byte value
    task automatic test_field_conversion();
        set_mode(MODE_OPENGL);
        send_string("1.2.3.4");
        send_string("9999.9999.9999.9999");
        send_string("0.0.0.0");
        send_string("12345.678901.1.1");
        send_string(" \t+7.-0.x9.5");
        load_text("1.2.3.");
        add_char(8'hFF);
        send_text();
        wait_for_idle();
    endtask

    // Field-count errors, negatives, NUL cut-off, empty string
    task automatic test_malformed_strings();
        send_string("1.-2.3.4");
        send_string("1.2.3");
        send_string("1.2.3.4.");
        send_string("1.2.3.4.5");
        send_string("");
        load_text("1.2.3.4");
        add_char(CH_NUL);
        add_char(CH_DOT);
        add_char(8'h35);
        send_text();
        load_text("1.2");
        add_char(CH_NUL);
        add_char(CH_DOT);
        add_char(8'h33);
        send_text();
        wait_for_idle();
    endtask

    // Vulkan: three fields ok, no padding, full form still converted
    task automatic test_short_form();
        set_mode(MODE_VULKAN);
        send_string("1.2.3");
        send_string("10.20.30.40");
        send_string("1.2");
        send_string("-1.2.3");
        send_string("1.2.3.");
        wait_for_idle();
    endtask

    task automatic test_random_opengl();
        set_mode(MODE_OPENGL);
        random_phase(380);
    endtask

    task automatic test_random_vulkan();
        set_mode(MODE_VULKAN);
        random_phase(380);
    endtask

    // Back-to-back beats on both sides
    task automatic test_full_rate();
        set_mode(MODE_OPENGL);
        max_gap   = 0;
        max_stall = 0;
        random_phase(200);
        max_gap   = 5;
        max_stall = 5;
    endtask

    // Receiver goes quiet while the sender keeps pushing: the result
    // register and input register fill and o_ready must drop
    task automatic test_backpressure();
        set_mode(MODE_VULKAN);
        hold_req = HOLD_CYCLES;
        while (hold_req != 0) @(posedge i_clk);
        max_gap = 0;
        repeat (12) begin
            build_random_text();
            send_text();
        end
        max_gap = 5;
        wait_for_idle();
    endtask

    // ---------------------------------------------------------------
    // Result receiver: random stalls plus the long hold on request
    // ---------------------------------------------------------------
    initial begin
        int stall;
        int hold;
        @(posedge i_rst_n);
        forever begin
            if (hold_req != 0) begin
                hold     = hold_req;
                hold_req = 0;
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            stall = $urandom_range(0, max_stall);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk);
            while (!(o_valid && i_ready) && hold_req == 0);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_version_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_versions.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat, version %h", o_version));
            end else begin
                exp_res = expected_versions.pop_front();
                results_seen++;
                if (o_valid_res === 1'b1) valid_results++;
                if (o_version !== exp_res.version)
                    report_mismatch($sformatf("result %0d: version %h, expected %h",
                                              results_seen, o_version, exp_res.version));
                if (o_valid_res !== exp_res.valid_res)
                    report_mismatch($sformatf("result %0d: valid_res %b, expected %b",
                                              results_seen, o_valid_res, exp_res.valid_res));
            end
        end
    end

    // Watchdog: no beat on either side and no APB traffic for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("HANG: no traffic for %0d cycles, %0d results outstanding",
                         HANG_LIMIT, expected_versions.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        mdl_mode = MODE_OPENGL;
        clear_parse_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_field_conversion();
        test_malformed_strings();
        test_short_form();
        test_random_opengl();
        test_random_vulkan();
        test_full_rate();
        test_backpressure();
        set_mode(MODE_OPENGL);
        random_phase(80);

        if (expected_versions.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_versions.size()));
        $display("Run: %0d character beats, %0d results checked, %0d of them valid",
                 beats_sent, results_seen, valid_results);
        $display("Both modes, corner strings, damaged and noisy text, full rate, a long hold");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: driver_version_string_parser.f
rtl/core/dvsp_pkg.sv
rtl/core/dvsp_field_conv.sv
rtl/core/dvsp_collect.sv
rtl/core/driver_version_string_parser.sv
sim/driver_version_string_parser_tb.sv
